/* rtl/saqp_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the slot array priority queue
// no dependencies

package saqp_pkg;

	// fixed field widths of the stream items
	localparam int PRIO_FIELD_W  = 10;
	localparam int PAYLOAD_W     = 16;
	localparam int INDEX_FIELD_W = 7;
	localparam int STATUS_W      = 2;
	localparam int S_TDATA_W     = 32;
	localparam int M_TDATA_W     = 40;

	// command codes carried on s_tuser
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	// status codes carried on m_tuser
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// sequencer to scan unit control
	typedef struct packed {
		logic start;  // clear the running result before a new scan
		logic vld;    // read data for one slot is present this cycle
		logic cmd;    // CMD_INSERT or CMD_POP
	} saqp_ctl_t;

endpackage

/* rtl/saqp_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module saqp_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/saqp_scan.sv */
`timescale 1ns / 1ps
// shared compare unit: walks slots one per cycle, keeps first free or best used slot
// depends on saqp_pkg

module saqp_scan #(
	parameter int AW            = 7,
	parameter int PRIORITY_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  saqp_pkg::saqp_ctl_t           ctl,
	input  logic                          rd_used,
	input  logic [PRIORITY_BITS-1:0]      rd_prio,
	input  logic [saqp_pkg::PAYLOAD_W-1:0] rd_pay,
	input  logic [AW-1:0]                 rd_idx,
	output logic                          found,
	output logic [AW-1:0]                 best_idx,
	output logic [PRIORITY_BITS-1:0]      best_prio,
	output logic [saqp_pkg::PAYLOAD_W-1:0] best_pay
);

	import saqp_pkg::*;

	logic found_q;
	logic [AW-1:0] idx_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic take;

	// insert wants the first free slot, pop the first used slot of greatest priority
	always_comb begin
		if (ctl.cmd == CMD_INSERT) begin
			take = ctl.vld && !found_q && !rd_used;
		end else begin
			take = ctl.vld && rd_used && (!found_q || (rd_prio > prio_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q  <= rd_idx;
			prio_q <= rd_prio;
			pay_q  <= rd_pay;
		end
	end

	assign found     = found_q;
	assign best_idx  = idx_q;
	assign best_prio = prio_q;
	assign best_pay  = pay_q;

endmodule

/* rtl/slot_array_priority_queue_unit.sv */
`timescale 1ns / 1ps
// top level of the slot array priority queue: sequencer, slot ram, scan unit, output register
// depends on saqp_pkg, saqp_ram, saqp_scan

// usage
//  - input channel s_*: s_tuser carries the command (insert or pop), s_tdata the
//    priority and payload to insert; a transfer happens when s_tvalid and s_tready
//    are both high
//  - output channel m_*: one result per command; m_tuser holds the status, m_tdata
//    the popped priority, popped payload and slot index
//  - every command walks all SLOTS entries of the slot ram through one read port
//    and one comparator, one slot per cycle; m_tvalid rises after the scan, drain
//    and done states, s_tready is low through those states, and a new command is
//    taken only once the sequencer is back in idle
//  - the result sits in an output register; the next command is taken while it
//    waits, and only the final write-back stalls until m_tready frees the register
//  - after arst_n the block runs a clearing pass over every slot of the slot ram
//    with s_tready low; then the queue is empty
//  - insert into a full queue reports full status, pop on an empty queue reports
//    empty status; neither changes the contents
//  - equal priorities pop the lowest slot first

module slot_array_priority_queue_unit #(
	parameter int SLOTS         = 128,
	parameter int PRIORITY_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [9:0] priority_req, [25:10] payload, rest zero
	input  logic [saqp_pkg::S_TDATA_W-1:0]    s_tdata,
	// [0] command
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [9:0] popped_priority, [25:10] popped_payload, [32:26] slot_index, rest zero
	output logic [saqp_pkg::M_TDATA_W-1:0]    m_tdata,
	// [1:0] status
	output logic [saqp_pkg::STATUS_W-1:0]     m_tuser
);

	import saqp_pkg::*;

	localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW  = 1 + PRIORITY_BITS + PAYLOAD_W;
	localparam int PIW = PRIORITY_BITS + PRIO_FIELD_W;
	localparam int IXW = AW + INDEX_FIELD_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] addr_q;        // clear pointer, then scan read pointer
	logic rd_vld_q;
	logic [AW-1:0] rd_idx_q;      // slot whose word is on the ram output

	// latched command
	logic cmd_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_W-1:0] pay_q;

	logic in_xfer;
	logic out_free;

	// ram ports
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic ram_re;
	logic [EW-1:0] ram_rdata;

	// scan unit
	saqp_ctl_t scan_ctl;
	logic scan_found;
	logic [AW-1:0] scan_idx;
	logic [PRIORITY_BITS-1:0] scan_prio;
	logic [PAYLOAD_W-1:0] scan_pay;

	// widened views for cutting fields to their port widths
	logic [PIW-1:0] prio_in_ext;
	logic [PIW-1:0] prio_out_ext;
	logic [IXW-1:0] idx_out_ext;

	// result being formed and the output register
	logic [STATUS_W-1:0] res_status;
	logic [PRIO_FIELD_W-1:0] res_prio;
	logic [PAYLOAD_W-1:0] res_pay;
	logic [INDEX_FIELD_W-1:0] res_idx;
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0] m_tuser_q;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	// the output register can take a new result this cycle
	assign out_free = !m_tvalid_q || m_tready;

	// incoming priority cut to the stored width
	assign prio_in_ext  = PIW'(s_tdata[PRIO_FIELD_W-1:0]);
	assign prio_out_ext = PIW'(scan_prio);
	assign idx_out_ext  = IXW'(scan_idx);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			addr_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == S_SCAN);
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_SLOT) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						addr_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_SLOT) begin
						addr_q  <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last slot word reaches the scan unit this cycle
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command capture and read index tracking
	always_ff @(posedge clk) begin
		rd_idx_q <= addr_q;
		if (in_xfer) begin
			cmd_q  <= s_tuser[0];
			prio_q <= prio_in_ext[PRIORITY_BITS-1:0];
			pay_q  <= s_tdata[PRIO_FIELD_W +: PAYLOAD_W];
		end
	end

	// ram access: clearing pass, scan reads, at most one write-back per command
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if ((state_q == S_DONE) && out_free && scan_found) begin
			ram_we    = 1'b1;
			ram_waddr = scan_idx;
			if (cmd_q == CMD_INSERT) begin
				ram_wdata = {1'b1, prio_q, pay_q};
			end else begin
				// pop frees the slot, contents stay
				ram_wdata = {1'b0, scan_prio, scan_pay};
			end
		end
	end

	assign ram_re = (state_q == S_SCAN);

	saqp_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign scan_ctl.start = in_xfer;
	assign scan_ctl.vld   = rd_vld_q;
	assign scan_ctl.cmd   = cmd_q;

	saqp_scan #(
		.AW            (AW),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.rd_used   (ram_rdata[EW-1]),
		.rd_prio   (ram_rdata[PAYLOAD_W +: PRIORITY_BITS]),
		.rd_pay    (ram_rdata[PAYLOAD_W-1:0]),
		.rd_idx    (rd_idx_q),
		.found     (scan_found),
		.best_idx  (scan_idx),
		.best_prio (scan_prio),
		.best_pay  (scan_pay)
	);

	// result fields; failed commands report zeros beside the status
	always_comb begin
		res_status = ST_DONE;
		res_prio   = '0;
		res_pay    = '0;
		res_idx    = '0;
		if (!scan_found) begin
			res_status = (cmd_q == CMD_INSERT) ? ST_FULL : ST_EMPTY;
		end else begin
			res_idx = idx_out_ext[INDEX_FIELD_W-1:0];
			if (cmd_q == CMD_POP) begin
				res_prio = prio_out_ext[PRIO_FIELD_W-1:0];
				res_pay  = scan_pay;
			end
		end
	end

	// output register, loaded once per command and held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_tdata_q <= M_TDATA_W'({res_idx, res_pay, res_prio});
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for slot_array_priority_queue_unit: random and directed commands
// against a behavioral copy of the slot array; depends on saqp_pkg and the rtl top

module tb_top;
	import saqp_pkg::*;

	localparam int SLOTS         = 128;
	localparam int PRIORITY_BITS = 10;
	localparam int RAND_ITEMS    = 1300;
	localparam int IDLE_LIMIT    = 3000;  // watchdog limit on cycles without any transfer
	localparam int DRAIN_CYCLES  = 300;   // tail after the last result
	localparam int MAX_PRINTS    = 40;

	// one command as the sender sees it
	typedef struct {
		logic                 cmd;
		logic [PRIO_FIELD_W-1:0] prio;
		logic [PAYLOAD_W-1:0] payload;
		int                   gap;          // cycles to idle before offering it
		bit                   drain_first;  // hold off until every result is back
	} cmd_item_t;

	// one predicted result
	typedef struct {
		logic [STATUS_W-1:0]      status;
		logic [PRIO_FIELD_W-1:0]  prio;
		logic [PAYLOAD_W-1:0]     payload;
		logic [INDEX_FIELD_W-1:0] slot;
	} pq_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	cmd_item_t  cmd_pending[$];
	pq_result_t results_due[$];

	// behavioral copy of the slot array
	bit                     q_used[SLOTS];
	logic [PRIORITY_BITS-1:0] q_prio[SLOTS];
	logic [PAYLOAD_W-1:0]   q_payload[SLOTS];

	int  errors;
	int  gap_left;
	int  rx_stall;
	int  rx_count;
	bit  rx_calm;
	bit  s_taken;
	int  idle_cycles;

	slot_array_priority_queue_unit #(
		.SLOTS         (SLOTS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// apply one command to the slot array copy and return what the block must report
	function automatic pq_result_t apply_command(input logic cmd,
			input logic [PRIO_FIELD_W-1:0] prio, input logic [PAYLOAD_W-1:0] payload);
		pq_result_t r;
		int best;
		r.status  = ST_DONE;
		r.prio    = '0;
		r.payload = '0;
		r.slot    = '0;
		best      = -1;
		if (cmd == CMD_INSERT) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!q_used[i] && best < 0) best = i;
			end
			if (best < 0) begin
				r.status = ST_FULL;
			end else begin
				q_used[best]    = 1'b1;
				q_prio[best]    = prio[PRIORITY_BITS-1:0];
				q_payload[best] = payload;
				r.slot          = best[INDEX_FIELD_W-1:0];
			end
		end else begin
			// strict greater keeps the lowest slot on a tie
			for (int i = 0; i < SLOTS; i++) begin
				if (q_used[i] && (best < 0 || q_prio[i] > q_prio[best])) best = i;
			end
			if (best < 0) begin
				r.status = ST_EMPTY;
			end else begin
				q_used[best] = 1'b0;
				r.prio       = PRIO_FIELD_W'(q_prio[best]);
				r.payload    = q_payload[best];
				r.slot       = best[INDEX_FIELD_W-1:0];
			end
		end
		return r;
	endfunction

	task automatic add_cmd(input logic cmd, input int prio, input int payload,
			input int gap, input bit drain_first);
		cmd_item_t it;
		it.cmd         = cmd;
		it.prio        = prio[PRIO_FIELD_W-1:0];
		it.payload     = payload[PAYLOAD_W-1:0];
		it.gap         = gap;
		it.drain_first = drain_first;
		cmd_pending.push_back(it);
	endtask

	// extremes, tie-prone small values and the full range
	function automatic int pick_prio();
		int p;
		case ($urandom_range(0, 3))
			0:       p = $urandom_range(0, 1) ? 1023 : 0;
			1:       p = $urandom_range(0, 3);
			default: p = $urandom_range(0, 1023);
		endcase
		return p;
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < MAX_PRINTS)
			$display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
		errors++;
	endtask

	// clock and reset
	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_INSERT;
		m_tready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		forever #1 clk = ~clk;
	end

	// stimulus: directed corner cases, then rounds biased toward filling, draining or balanced
	initial begin
		int total;
		int ins_pct;
		int len;
		bit calm;
		bit first;
		errors   = 0;
		gap_left = -1;
		rx_stall = 0;
		rx_count = 0;
		rx_calm  = 1'b0;

		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);  // pop on an empty queue
		add_cmd(CMD_INSERT, 1023, 16'hffff, 3, 1'b0);
		add_cmd(CMD_INSERT, 0,    16'h0000, 0, 1'b0);
		add_cmd(CMD_INSERT, 1023, 16'h1234, 5, 1'b0);  // tie with slot 0
		add_cmd(CMD_INSERT, 512,  16'haaaa, 0, 1'b0);
		add_cmd(CMD_POP,    1023, 16'hffff, 9, 1'b0);  // ignored fields set, tie goes to slot 0
		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);
		add_cmd(CMD_INSERT, 5,    16'h5555, 0, 1'b0);  // reuses the lowest free slot
		add_cmd(CMD_INSERT, 1,    16'h8001, 2, 1'b0);
		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);
		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);
		add_cmd(CMD_POP,    0,    16'h0000, 7, 1'b0);
		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);
		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);  // empty again
		add_cmd(CMD_INSERT, 682,  16'h5a5a, 0, 1'b0);
		add_cmd(CMD_INSERT, 341,  16'ha5a5, 0, 1'b0);
		add_cmd(CMD_INSERT, 341,  16'h0f0f, 0, 1'b0);
		add_cmd(CMD_POP,    682,  16'hf0f0, 0, 1'b0);
		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);
		add_cmd(CMD_POP,    0,    16'h0000, 0, 1'b0);

		total = 0;
		first = 1'b1;
		while (total < RAND_ITEMS) begin
			if (first) begin
				ins_pct = 95;  // first round runs into a full queue
				len     = 200;
			end else begin
				case ($urandom_range(0, 2))
					0:       ins_pct = 90;
					1:       ins_pct = 10;
					default: ins_pct = 50;
				endcase
				len = $urandom_range(60, 180);
			end
			calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				add_cmd(($urandom_range(1, 100) <= ins_pct) ? CMD_INSERT : CMD_POP,
					pick_prio(), $urandom_range(0, 65535),
					calm ? 0 : $urandom_range(0, 9),
					(k == 0) && (first || $urandom_range(0, 2) == 0));
			end
			first = 1'b0;
			total += len;
		end

		@(posedge clk);
		while (cmd_pending.size() != 0 || s_tvalid || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// command driver: offers the next pending item after its gap, holds it until the transfer
	always @(negedge clk) begin : drive_cmd
		cmd_item_t it;
		if (arst_n) begin
			if (s_tvalid && !s_taken) begin
				// still waiting for the transfer
			end else if (cmd_pending.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (cmd_pending[0].drain_first && results_due.size() != 0) begin
				s_tvalid <= 1'b0;
			end else begin
				if (gap_left < 0) gap_left = cmd_pending[0].gap;
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					it       = cmd_pending.pop_front();
					gap_left = -1;
					s_tvalid <= 1'b1;
					s_tuser  <= it.cmd;
					s_tdata  <= {{(S_TDATA_W-PAYLOAD_W-PRIO_FIELD_W){1'b0}}, it.payload, it.prio};
				end
			end
		end
	end

	// result sink: stall counts only while a result is offered
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= (rx_stall == 0);
			if (m_tvalid && rx_stall > 0) rx_stall--;
		end
	end

	// prediction on each command transfer, checking on each result transfer, watchdog
	always @(posedge clk) begin : check_results
		pq_result_t want;
		if (!arst_n) begin
			s_taken     <= 1'b0;
			idle_cycles = 0;
		end else begin
			s_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				results_due.push_back(apply_command(s_tuser[0],
					s_tdata[PRIO_FIELD_W-1:0], s_tdata[PRIO_FIELD_W +: PAYLOAD_W]));

			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					flag_mismatch("unexpected result", m_tdata[31:0], 32'h0);
				end else begin
					want = results_due.pop_front();
					if (m_tuser !== want.status)
						flag_mismatch("status", 32'(m_tuser), 32'(want.status));
					if (m_tdata[PRIO_FIELD_W-1:0] !== want.prio)
						flag_mismatch("popped_priority", 32'(m_tdata[PRIO_FIELD_W-1:0]),
							32'(want.prio));
					if (m_tdata[PRIO_FIELD_W +: PAYLOAD_W] !== want.payload)
						flag_mismatch("popped_payload", 32'(m_tdata[PRIO_FIELD_W +: PAYLOAD_W]),
							32'(want.payload));
					if (m_tdata[PRIO_FIELD_W+PAYLOAD_W +: INDEX_FIELD_W] !== want.slot)
						flag_mismatch("slot_index",
							32'(m_tdata[PRIO_FIELD_W+PAYLOAD_W +: INDEX_FIELD_W]), 32'(want.slot));
					if (m_tdata[M_TDATA_W-1:PRIO_FIELD_W+PAYLOAD_W+INDEX_FIELD_W] !== '0)
						flag_mismatch("tdata padding",
							32'(m_tdata[M_TDATA_W-1:PRIO_FIELD_W+PAYLOAD_W+INDEX_FIELD_W]), 32'h0);
				end
				// calm stretches of the sink change every 64 results
				rx_count++;
				if (rx_count % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
				rx_stall = rx_calm ? 0 : $urandom_range(0, 9);
			end

			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule

/* slot_array_priority_queue_unit.f */
rtl/saqp_pkg.sv
rtl/saqp_ram.sv
rtl/saqp_scan.sv
rtl/slot_array_priority_queue_unit.sv
tb/tb_top.sv
